// ----- hdl/light_sensor_poll_sequencer_macros.svh -----
// Assertion macros for the light sensor poll sequencer.
// Used by the top level; depends on a clock named i_clk and a reset named i_rst_n.
`ifndef LIGHT_SENSOR_POLL_SEQUENCER_MACROS_SVH
`define LIGHT_SENSOR_POLL_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define LSPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define LSPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lsps_pkg.sv -----
// Shared types, codes and the lux conversion for the light sensor poll sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsps_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_POWER = 3'd1,
        PH_MODE  = 3'd2,
        PH_WAIT  = 3'd3,
        PH_READ  = 3'd4,
        PH_DONE  = 3'd5,
        PH_ERROR = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        OP_STEP    = 2'd0,
        OP_INIT    = 2'd1,
        OP_TRIGGER = 2'd2,
        OP_TAKE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        REG_SINGLE_SHOT = 3'd0,
        REG_INTERVAL    = 3'd1,
        REG_DEV_ADDR    = 3'd2,
        REG_RETRY_LIMIT = 3'd3,
        REG_SETTLE      = 3'd4,
        REG_MEASURE     = 3'd5,
        REG_HOLDOFF     = 3'd6
    } t_reg_idx;

    localparam logic [7:0] CMD_NONE      = 8'h00;
    localparam logic [7:0] CMD_POWER_ON  = 8'h01;
    localparam logic [7:0] CMD_MODE_CONT = 8'h10;
    localparam logic [7:0] CMD_MODE_ONCE = 8'h20;

    localparam logic [15:0] RST_INTERVAL_MS = 16'd180;
    localparam logic [6:0]  RST_DEV_ADDR    = 7'd35;
    localparam logic [3:0]  RST_RETRY_LIMIT = 4'd3;
    localparam logic [15:0] RST_SETTLE_MS   = 16'd10;
    localparam logic [15:0] RST_MEASURE_MS  = 16'd180;
    localparam logic [15:0] RST_HOLDOFF_MS  = 16'd2000;

    // Reciprocal of three for exact division of a 16-bit value: (x * 43691) >> 17.
    localparam logic [16:0] RECIP_THREE = 17'd43691;

    typedef struct packed {
        logic        single_shot;
        logic [15:0] interval_ms;
        logic [6:0]  dev_addr;
        logic [3:0]  retry_limit;
        logic [15:0] settle_ms;
        logic [15:0] measure_ms;
        logic [15:0] holdoff_ms;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [31:0] now_ms;
        logic        bus_ok;
        logic [15:0] bus_read_data;
    } t_in_item;

    typedef struct packed {
        t_action     bus_action;
        logic [7:0]  command_byte;
        logic        bus_recover;
        logic [19:0] lux_value;
        logic        lux_ready;
        logic        lux_taken;
        t_phase      phase_code;
    } t_result;

    // raw * 25 / 3 equals raw * 8 + floor(raw / 3).
    function automatic logic [19:0] lux_of(input logic [15:0] raw);
        logic [32:0] prod;
        logic [15:0] third;
        prod  = {17'b0, raw} * {16'b0, RECIP_THREE};
        third = prod[32:17];
        return {1'b0, raw, 3'b000} + {4'b0, third};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/light_sensor_poll_sequencer.sv -----
// Channel   | Direction | Handshake                 | Carries
// in        | into      | i_in_valid / o_in_ready   | op, now_ms, bus_ok, bus_read_data
// out       | out of    | o_out_valid / i_out_ready | action, command, recover, lux, phase
// cfg       | into      | psel, penable, pwrite     | seven registers at 4*index
// An input beat is registered, stepped and its result registered: one beat per cycle,
// set by the single step stage, while the output is not stalled.
// Reset is synchronous and clears all sequencer state and the valid flags of both beat registers.
// A stalled output holds the stage behind it; the input takes a beat whenever the step
// stage is empty or moving. Depends on lsps_pkg, lsps_cfg, lsps_step and the macro header.
`default_nettype none

`include "light_sensor_poll_sequencer_macros.svh"

module light_sensor_poll_sequencer
    import lsps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_bus_ok,
    input  wire logic [15:0] i_bus_read_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [1:0]  o_bus_action,
    output logic      [7:0]  o_command_byte,
    output logic             o_bus_recover,
    output logic      [19:0] o_lux_value,
    output logic             o_lux_ready,
    output logic             o_lux_taken,
    output logic      [2:0]  o_phase_code
);

    t_cfg     cfg;
    t_in_item r_in;
    logic     r_in_valid;
    t_result  step_res;
    t_result  r_out;
    logic     r_out_valid;
    logic     adv;

    lsps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.op            <= t_op'(i_op);
            r_in.now_ms        <= i_now_ms;
            r_in.bus_ok        <= i_bus_ok;
            r_in.bus_read_data <= i_bus_read_data;
        end
    end

    lsps_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bus_action   = r_out.bus_action;
    assign o_command_byte = r_out.command_byte;
    assign o_bus_recover  = r_out.bus_recover;
    assign o_lux_value    = r_out.lux_value;
    assign o_lux_ready    = r_out.lux_ready;
    assign o_lux_taken    = r_out.lux_taken;
    assign o_phase_code   = r_out.phase_code;

    `LSPS_ASSERT_NOW(a_recover_enters_error, r_out_valid && r_out.bus_recover, r_out.phase_code == PH_ERROR, "Recovery request without error phase.")
    `LSPS_ASSERT_NOW(a_taken_clears_ready, r_out_valid && r_out.lux_taken, !r_out.lux_ready, "Result taken but still marked ready.")
    `LSPS_ASSERT_NOW(a_cmd_only_on_write, r_out_valid && (r_out.bus_action != ACT_WRITE), r_out.command_byte == CMD_NONE, "Command byte set without a write.")
    `LSPS_ASSERT_NEXT(a_step_stage_holds, r_in_valid && !adv, r_in_valid, "Step stage dropped a beat while blocked.")

endmodule

`default_nettype wire

// ----- hdl/lsps_cfg.sv -----
// Configuration register file with an APB-style write and read port.
// Depends on lsps_pkg for the register indexes, reset values and t_cfg.
`default_nettype none

module lsps_cfg
    import lsps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.single_shot <= 1'b0;
            r_cfg.interval_ms <= RST_INTERVAL_MS;
            r_cfg.dev_addr    <= RST_DEV_ADDR;
            r_cfg.retry_limit <= RST_RETRY_LIMIT;
            r_cfg.settle_ms   <= RST_SETTLE_MS;
            r_cfg.measure_ms  <= RST_MEASURE_MS;
            r_cfg.holdoff_ms  <= RST_HOLDOFF_MS;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_SINGLE_SHOT: r_cfg.single_shot <= pwdata[0];
                REG_INTERVAL:    r_cfg.interval_ms <= pwdata[15:0];
                REG_DEV_ADDR:    r_cfg.dev_addr    <= pwdata[6:0];
                REG_RETRY_LIMIT: r_cfg.retry_limit <= pwdata[3:0];
                REG_SETTLE:      r_cfg.settle_ms   <= pwdata[15:0];
                REG_MEASURE:     r_cfg.measure_ms  <= pwdata[15:0];
                REG_HOLDOFF:     r_cfg.holdoff_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SINGLE_SHOT: prdata = {31'b0, r_cfg.single_shot};
            REG_INTERVAL:    prdata = {16'b0, r_cfg.interval_ms};
            REG_DEV_ADDR:    prdata = {25'b0, r_cfg.dev_addr};
            REG_RETRY_LIMIT: prdata = {28'b0, r_cfg.retry_limit};
            REG_SETTLE:      prdata = {16'b0, r_cfg.settle_ms};
            REG_MEASURE:     prdata = {16'b0, r_cfg.measure_ms};
            REG_HOLDOFF:     prdata = {16'b0, r_cfg.holdoff_ms};
            default:         prdata = 32'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/lsps_step.sv -----
// Sequencer state and the combinational step logic that produces one result per beat.
// Depends on lsps_pkg for phases, ops, actions, commands and the lux conversion.
`default_nettype none

module lsps_step
    import lsps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_result   o_result
);

    t_phase      r_phase,  n_phase;
    logic [31:0] r_start,  n_start;
    logic        r_mode_sent, n_mode_sent;
    logic [3:0]  r_retry,  n_retry;
    logic [19:0] r_lux,    n_lux;
    logic        r_ready,  n_ready;

    t_action     act;
    logic [7:0]  cmd;
    logic        recover;
    logic        taken;
    logic [31:0] elapsed;
    logic [3:0]  retry_inc;
    logic        fail_hit;
    logic [15:0] wait_ms;

    assign elapsed   = i_item.now_ms - r_start;
    assign retry_inc = r_retry + 4'd1;
    assign fail_hit  = (retry_inc >= i_cfg.retry_limit);
    assign wait_ms   = i_cfg.single_shot ? i_cfg.measure_ms : i_cfg.interval_ms;

    always_comb begin
        n_phase     = r_phase;
        n_start     = r_start;
        n_mode_sent = r_mode_sent;
        n_retry     = r_retry;
        n_lux       = r_lux;
        n_ready     = r_ready;
        act         = ACT_NONE;
        cmd         = CMD_NONE;
        recover     = 1'b0;
        taken       = 1'b0;

        unique case (i_item.op)
            OP_INIT: begin
                n_phase     = PH_POWER;
                n_start     = i_item.now_ms;
                n_retry     = 4'd0;
                n_mode_sent = 1'b0;
                n_ready     = 1'b0;
            end
            OP_TRIGGER: begin
                if (i_cfg.single_shot) begin
                    n_phase = PH_IDLE;
                end
            end
            OP_TAKE: begin
                if (r_ready) begin
                    n_ready = 1'b0;
                    taken   = 1'b1;
                end
            end
            OP_STEP: begin
                unique case (r_phase)
                    PH_POWER: begin
                        act = ACT_WRITE;
                        cmd = CMD_POWER_ON;
                        if (i_item.bus_ok) begin
                            n_start     = i_item.now_ms;
                            n_phase     = PH_MODE;
                            n_mode_sent = 1'b0;
                            n_retry     = 4'd0;
                        end else begin
                            n_retry = retry_inc;
                            if (fail_hit) begin
                                n_phase = PH_ERROR;
                                n_start = i_item.now_ms;
                                recover = 1'b1;
                            end
                        end
                    end
                    PH_MODE: begin
                        if (elapsed >= {16'b0, i_cfg.settle_ms}) begin
                            if (!r_mode_sent) begin
                                act = ACT_WRITE;
                                cmd = i_cfg.single_shot ? CMD_MODE_ONCE : CMD_MODE_CONT;
                                if (i_item.bus_ok) begin
                                    n_mode_sent = 1'b1;
                                    n_start     = i_item.now_ms;
                                    n_retry     = 4'd0;
                                end else begin
                                    n_retry = retry_inc;
                                    if (fail_hit) begin
                                        n_phase = PH_ERROR;
                                        n_start = i_item.now_ms;
                                        recover = 1'b1;
                                    end
                                end
                            end else if (elapsed >= {16'b0, i_cfg.measure_ms}) begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    PH_IDLE: begin
                        if (!i_cfg.single_shot) begin
                            n_start = i_item.now_ms;
                            n_phase = PH_WAIT;
                        end else begin
                            act = ACT_WRITE;
                            cmd = CMD_MODE_ONCE;
                            if (i_item.bus_ok) begin
                                n_start = i_item.now_ms;
                                n_phase = PH_WAIT;
                                n_retry = 4'd0;
                            end else begin
                                n_retry = retry_inc;
                                if (fail_hit) begin
                                    n_phase = PH_ERROR;
                                    n_start = i_item.now_ms;
                                    recover = 1'b1;
                                end
                            end
                        end
                    end
                    PH_WAIT: begin
                        if (elapsed >= {16'b0, wait_ms}) begin
                            act = ACT_READ;
                            if (i_item.bus_ok) begin
                                n_lux   = lux_of(i_item.bus_read_data);
                                n_ready = 1'b1;
                                n_phase = PH_DONE;
                                n_retry = 4'd0;
                            end else begin
                                n_retry = retry_inc;
                                if (fail_hit) begin
                                    n_phase = PH_ERROR;
                                    n_start = i_item.now_ms;
                                    recover = 1'b1;
                                end
                            end
                        end
                    end
                    PH_DONE: begin
                        if (!r_ready) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_ERROR: begin
                        if (elapsed > {16'b0, i_cfg.holdoff_ms}) begin
                            n_phase     = PH_POWER;
                            n_start     = i_item.now_ms;
                            n_retry     = 4'd0;
                            n_mode_sent = 1'b0;
                            n_ready     = 1'b0;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_start     <= 32'd0;
            r_mode_sent <= 1'b0;
            r_retry     <= 4'd0;
            r_lux       <= 20'd0;
            r_ready     <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_start     <= n_start;
            r_mode_sent <= n_mode_sent;
            r_retry     <= n_retry;
            r_lux       <= n_lux;
            r_ready     <= n_ready;
        end
    end

    assign o_result.bus_action   = act;
    assign o_result.command_byte = cmd;
    assign o_result.bus_recover  = recover;
    assign o_result.lux_value    = n_lux;
    assign o_result.lux_ready    = n_ready;
    assign o_result.lux_taken    = taken;
    assign o_result.phase_code   = n_phase;

endmodule

`default_nettype wire

// ----- test/tb_light_sensor_poll_sequencer.sv -----
// Self-checking testbench for the light sensor poll sequencer, driving its step beats and
// checking each result beat against a cycle-free model of the polling sequence.
// Depends on lsps_pkg and the light_sensor_poll_sequencer top level.
`timescale 1ns / 1ps

module tb_light_sensor_poll_sequencer;
    import lsps_pkg::*;

    localparam logic [4:0] UNMAPPED_REG_ADDR = 5'd28;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = OP_STEP;
    logic [31:0] i_now_ms = '0;
    logic        i_bus_ok = 1'b0;
    logic [15:0] i_bus_read_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_bus_action;
    logic [7:0]  o_command_byte;
    logic        o_bus_recover;
    logic [19:0] o_lux_value;
    logic        o_lux_ready;
    logic        o_lux_taken;
    logic [2:0]  o_phase_code;

    light_sensor_poll_sequencer dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_op(i_op),
        .i_now_ms(i_now_ms),
        .i_bus_ok(i_bus_ok),
        .i_bus_read_data(i_bus_read_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_bus_action(o_bus_action),
        .o_command_byte(o_command_byte),
        .o_bus_recover(o_bus_recover),
        .o_lux_value(o_lux_value),
        .o_lux_ready(o_lux_ready),
        .o_lux_taken(o_lux_taken),
        .o_phase_code(o_phase_code)
    );

    t_cfg seq_cfg = '{single_shot: 1'b0, interval_ms: RST_INTERVAL_MS, dev_addr: RST_DEV_ADDR,
                      retry_limit: RST_RETRY_LIMIT, settle_ms: RST_SETTLE_MS,
                      measure_ms: RST_MEASURE_MS, holdoff_ms: RST_HOLDOFF_MS};
    t_phase      seq_phase = PH_IDLE;
    logic [31:0] seq_start_ms = '0;
    logic        seq_mode_sent = 1'b0;
    logic [3:0]  seq_retries = '0;
    logic [19:0] seq_lux = '0;
    logic        seq_ready = 1'b0;

    t_in_item poll_items[$];
    t_result  poll_results_due[$];
    logic [31:0] clock_ms = '0;
    logic in_beat_taken = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int beats_in = 0;
    int results_checked = 0;
    int reads_seen = 0;
    int recoveries_seen = 0;
    int takes_seen = 0;

    function automatic void begin_init(logic [31:0] now);
        seq_phase = PH_POWER;
        seq_start_ms = now;
        seq_retries = '0;
        seq_mode_sent = 1'b0;
        seq_ready = 1'b0;
    endfunction

    function automatic logic count_failure(logic [31:0] now);
        seq_retries = seq_retries + 4'd1;
        if (seq_retries >= seq_cfg.retry_limit) begin
            seq_phase = PH_ERROR;
            seq_start_ms = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [31:0] data);
        case (idx)
            REG_SINGLE_SHOT: seq_cfg.single_shot = data[0];
            REG_INTERVAL:    seq_cfg.interval_ms = data[15:0];
            REG_DEV_ADDR:    seq_cfg.dev_addr = data[6:0];
            REG_RETRY_LIMIT: seq_cfg.retry_limit = data[3:0];
            REG_SETTLE:      seq_cfg.settle_ms = data[15:0];
            REG_MEASURE:     seq_cfg.measure_ms = data[15:0];
            REG_HOLDOFF:     seq_cfg.holdoff_ms = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic t_result step_sequencer(t_in_item beat);
        t_result     res;
        logic [31:0] elapsed;
        logic [31:0] scaled;
        logic [15:0] wait_ms;
        res = '0;
        res.bus_action = ACT_NONE;
        res.command_byte = CMD_NONE;
        elapsed = beat.now_ms - seq_start_ms;
        case (beat.op)
            OP_INIT: begin_init(beat.now_ms);
            OP_TRIGGER: if (seq_cfg.single_shot) seq_phase = PH_IDLE;
            OP_TAKE: if (seq_ready) begin
                seq_ready = 1'b0;
                res.lux_taken = 1'b1;
            end
            default: begin
                case (seq_phase)
                    PH_POWER: begin
                        res.bus_action = ACT_WRITE;
                        res.command_byte = CMD_POWER_ON;
                        if (beat.bus_ok) begin
                            seq_start_ms = beat.now_ms;
                            seq_phase = PH_MODE;
                            seq_mode_sent = 1'b0;
                            seq_retries = '0;
                        end else begin
                            res.bus_recover = count_failure(beat.now_ms);
                        end
                    end
                    PH_MODE: if (elapsed >= {16'b0, seq_cfg.settle_ms}) begin
                        if (!seq_mode_sent) begin
                            res.bus_action = ACT_WRITE;
                            if (seq_cfg.single_shot) res.command_byte = CMD_MODE_ONCE;
                            else res.command_byte = CMD_MODE_CONT;
                            if (beat.bus_ok) begin
                                seq_mode_sent = 1'b1;
                                seq_start_ms = beat.now_ms;
                                seq_retries = '0;
                            end else begin
                                res.bus_recover = count_failure(beat.now_ms);
                            end
                        end else if (elapsed >= {16'b0, seq_cfg.measure_ms}) begin
                            seq_phase = PH_IDLE;
                        end
                    end
                    PH_IDLE: begin
                        if (!seq_cfg.single_shot) begin
                            seq_start_ms = beat.now_ms;
                            seq_phase = PH_WAIT;
                        end else begin
                            res.bus_action = ACT_WRITE;
                            res.command_byte = CMD_MODE_ONCE;
                            if (beat.bus_ok) begin
                                seq_start_ms = beat.now_ms;
                                seq_phase = PH_WAIT;
                                seq_retries = '0;
                            end else begin
                                res.bus_recover = count_failure(beat.now_ms);
                            end
                        end
                    end
                    PH_WAIT: begin
                        wait_ms = seq_cfg.single_shot ? seq_cfg.measure_ms : seq_cfg.interval_ms;
                        if (elapsed >= {16'b0, wait_ms}) begin
                            res.bus_action = ACT_READ;
                            if (beat.bus_ok) begin
                                scaled = {16'b0, beat.bus_read_data} * 32'd25 / 32'd3;
                                seq_lux = scaled[19:0];
                                seq_ready = 1'b1;
                                seq_phase = PH_DONE;
                                seq_retries = '0;
                            end else begin
                                res.bus_recover = count_failure(beat.now_ms);
                            end
                        end
                    end
                    PH_DONE: if (!seq_ready) seq_phase = PH_IDLE;
                    PH_ERROR: if (elapsed > {16'b0, seq_cfg.holdoff_ms}) begin
                        begin_init(beat.now_ms);
                    end
                    default: seq_phase = PH_IDLE;
                endcase
            end
        endcase
        res.lux_value = seq_lux;
        res.lux_ready = seq_ready;
        res.phase_code = seq_phase;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        t_in_item next_beat;
        if (i_rst_n && (!i_in_valid || in_beat_taken)) begin
            if (poll_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_beat = poll_items.pop_front();
                i_op <= next_beat.op;
                i_now_ms <= next_beat.now_ms;
                i_bus_ok <= next_beat.bus_ok;
                i_bus_read_data <= next_beat.bus_read_data;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_in_item beat;
        t_result  want;
        in_beat_taken = i_rst_n && i_in_valid && o_in_ready;
        if (in_beat_taken) begin
            beat.op = t_op'(i_op);
            beat.now_ms = i_now_ms;
            beat.bus_ok = i_bus_ok;
            beat.bus_read_data = i_bus_read_data;
            poll_results_due.push_back(step_sequencer(beat));
            beats_in++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (poll_results_due.size() == 0) begin
                mismatches++;
                $display({"%0t ns: result beat mismatch, expected none, ",
                          "actual phase %0d action %0d"},
                         $time, o_phase_code, o_bus_action);
            end else begin
                want = poll_results_due.pop_front();
                check_field("bus_action", want.bus_action, o_bus_action);
                check_field("command_byte", want.command_byte, o_command_byte);
                check_field("bus_recover", want.bus_recover, o_bus_recover);
                check_field("lux_value", want.lux_value, o_lux_value);
                check_field("lux_ready", want.lux_ready, o_lux_ready);
                check_field("lux_taken", want.lux_taken, o_lux_taken);
                check_field("phase_code", want.phase_code, o_phase_code);
                results_checked++;
                if (want.bus_action == ACT_READ) reads_seen++;
                if (want.bus_recover) recoveries_seen++;
                if (want.lux_taken) takes_seen++;
            end
        end
    end

    task automatic queue_poll(t_op op, logic ok, logic [15:0] raw);
        t_in_item beat;
        beat.op = op;
        beat.now_ms = clock_ms;
        beat.bus_ok = ok;
        beat.bus_read_data = raw;
        poll_items.push_back(beat);
    endtask

    task automatic queue_random_polls(int count, int step_max, int ok_pct);
        int   pick;
        t_op  op;
        logic [15:0] raw;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 5) clock_ms = $urandom();
            else if (pick < 15) clock_ms += $urandom_range(4 * step_max);
            else if (pick >= 25) clock_ms += $urandom_range(step_max);
            pick = $urandom_range(99);
            if (pick < 74) op = OP_STEP;
            else if (pick < 79) op = OP_INIT;
            else if (pick < 86) op = OP_TRIGGER;
            else op = OP_TAKE;
            pick = $urandom_range(9);
            if (pick == 0) raw = 16'h0000;
            else if (pick == 1) raw = 16'hFFFF;
            else raw = 16'($urandom_range(16'hFFFF));
            queue_poll(op, $urandom_range(99) < ok_pct, raw);
        end
    endtask

    task automatic settle_pipeline();
        while (poll_items.size() > 0 || i_in_valid || poll_results_due.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(logic [4:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_register(addr[4:2], data);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic single, logic [15:0] interval, logic [6:0] addr,
                             logic [3:0] retries, logic [15:0] settle,
                             logic [15:0] measure, logic [15:0] holdoff);
        write_register({REG_SINGLE_SHOT, 2'b00}, {31'b0, single});
        write_register({REG_INTERVAL, 2'b00}, {16'b0, interval});
        write_register({REG_DEV_ADDR, 2'b00}, {25'b0, addr});
        write_register({REG_RETRY_LIMIT, 2'b00}, {28'b0, retries});
        write_register({REG_SETTLE, 2'b00}, {16'b0, settle});
        write_register({REG_MEASURE, 2'b00}, {16'b0, measure});
        write_register({REG_HOLDOFF, 2'b00}, {16'b0, holdoff});
    endtask

    // The stream is split in two so that the sender drains the block in mid phase.
    task automatic run_poll_phase(int count, int step_max, int ok_pct, int idle_pct,
                                  int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        queue_poll(OP_INIT, 1'b1, 16'h0000);
        queue_random_polls(count / 2, step_max, ok_pct);
        settle_pipeline();
        queue_random_polls(count - count / 2, step_max, ok_pct);
        settle_pipeline();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full sequence at reset settings, crossing the millisecond wrap in the mode phase.
        clock_ms = 32'hFFFF_FFF0;
        queue_poll(OP_TAKE, 1'b1, 16'h1234);
        queue_poll(OP_TRIGGER, 1'b0, 16'hFFFF);
        queue_poll(OP_INIT, 1'b0, 16'hFFFF);
        queue_poll(OP_STEP, 1'b0, 16'h0000);
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        clock_ms += 5;
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        clock_ms += 5;
        queue_poll(OP_STEP, 1'b0, 16'h0000);
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        clock_ms += 90;
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        clock_ms += 90;
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        clock_ms += 179;
        queue_poll(OP_STEP, 1'b1, 16'h5555);
        clock_ms += 1;
        queue_poll(OP_STEP, 1'b1, 16'hFFFF);
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        queue_poll(OP_TAKE, 1'b0, 16'h0000);
        queue_poll(OP_TAKE, 1'b1, 16'hFFFF);
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        clock_ms += 180;
        queue_poll(OP_STEP, 1'b0, 16'hAAAA);
        queue_poll(OP_STEP, 1'b0, 16'h0000);
        queue_poll(OP_STEP, 1'b0, 16'h0000);
        clock_ms += 2000;
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        clock_ms += 1;
        queue_poll(OP_STEP, 1'b1, 16'h0000);
        settle_pipeline();

        configure(1'b0, 16'd6, 7'd0, 4'd2, 16'd3, 16'd5, 16'd15);
        run_poll_phase(120, 4, 90, 0, 0);
        configure(1'b1, 16'd0, 7'd127, 4'd1, 16'd0, 16'd0, 16'd0);
        run_poll_phase(120, 3, 85, 71, 0);
        configure(1'b1, 16'd9, 7'd85, 4'd15, 16'd4, 16'd7, 16'd30);
        run_poll_phase(140, 4, 20, 0, 71);
        configure(1'b0, 16'd12, 7'd42, 4'd0, 16'd8, 16'd3, 16'd5);
        run_poll_phase(140, 5, 80, 36, 36);
        configure(1'b0, 16'hFFFF, 7'd0, 4'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_poll_phase(100, 25000, 90, 71, 0);
        configure(1'b0, RST_INTERVAL_MS, RST_DEV_ADDR, RST_RETRY_LIMIT, RST_SETTLE_MS,
                  RST_MEASURE_MS, RST_HOLDOFF_MS);
        write_register(UNMAPPED_REG_ADDR, $urandom());
        run_poll_phase(130, 60, 85, 36, 36);

        $display("Polling run covered %0d step beats in, %0d result beats checked.",
                 beats_in, results_checked);
        $display("It saw %0d sensor reads, %0d bus recoveries and %0d taken results.",
                 reads_seen, recoveries_seen, takes_seen);
        if (mismatches == 0) begin
            $display("light_sensor_poll_sequencer verification clean");
        end else begin
            $display("light_sensor_poll_sequencer verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results still expected.", poll_results_due.size());
        $display("light_sensor_poll_sequencer verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/lsps_pkg.sv
hdl/lsps_cfg.sv
hdl/lsps_step.sv
hdl/light_sensor_poll_sequencer.sv
test/tb_light_sensor_poll_sequencer.sv
